>>> hdl/rmgq_pkg.sv
// Shared types and constants of the role matched group queue.
package rmgq_pkg;

   localparam int DEPTH_DEFAULT   = 128;
   localparam int ID_BITS_DEFAULT = 16;
   localparam int NUM_ROLES       = 3;
   localparam int ENTRY_ID_BITS   = 16;
   localparam int FILL_BITS       = 8;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_GROUP = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [1:0] ROLE_NONE = 2'd3;

   typedef struct packed {
      logic                     push;
      logic                     pop_role;
      logic                     take_group;
      logic [1:0]               role;
      logic [ENTRY_ID_BITS-1:0] id;
   } cmd_type;

endpackage

>>> hdl/rmgq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rmgq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rmgq_front.sv
// Front end: accepts request beats, decodes them and holds them in a two-entry queue.
module rmgq_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [1:0]                          in_op,
   input  logic [rmgq_pkg::ENTRY_ID_BITS-1:0]  in_id,
   input  logic [1:0]                          in_role,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output rmgq_pkg::cmd_type                   cmd
);
   import rmgq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       do_push, do_pop;

   always_comb begin
      dec           = '0;
      dec.role      = in_role;
      dec.id        = in_id;
      case (in_op)
         OP_PUSH:  dec.push       = (in_role != ROLE_NONE);
         OP_POP:   dec.pop_role   = (in_role != ROLE_NONE);
         OP_GROUP: dec.take_group = 1'b1;
         default:  dec.push       = 1'b0;
      endcase
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> hdl/rmgq_back.sv
// Back end: keeps one ordered list per role in RAM and produces the status result.
module rmgq_back #(
   parameter int DEPTH   = rmgq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = rmgq_pkg::ID_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rmgq_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_data
);
   import rmgq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int TW = CW + 2;
   localparam int SW = (ID_BITS < ENTRY_ID_BITS) ? ID_BITS : ENTRY_ID_BITS;

   typedef enum logic [2:0] {
      S_EXEC = 3'b001,
      S_READ = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff    [NUM_ROLES];
   logic [CW-1:0] cnt_in    [NUM_ROLES];
   logic [AW-1:0] rd_ptr_ff [NUM_ROLES];
   logic [AW-1:0] rd_ptr_in [NUM_ROLES];
   logic [AW-1:0] wr_ptr_ff [NUM_ROLES];
   logic [AW-1:0] wr_ptr_in [NUM_ROLES];
   logic [NUM_ROLES-1:0] wr_en;
   logic [SW-1:0] head      [NUM_ROLES];
   logic          dropped_ff, dropped_in;
   logic [TW-1:0] total;
   logic [CW+FILL_BITS-1:0] total_ext;
   logic [NUM_ROLES-1:0] have;
   logic [ENTRY_ID_BITS-1:0] head_id [NUM_ROLES];
   logic          exec;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign exec      = (state_ff == S_EXEC) && cmd_valid;
   assign cmd_ready = (state_ff == S_EXEC);
   assign total     = TW'(cnt_ff[0]) + TW'(cnt_ff[1]) + TW'(cnt_ff[2]);

   always_comb begin
      for (int r = 0; r < NUM_ROLES; r++) begin
         have[r] = (cnt_ff[r] != '0);
      end
   end

   always_comb begin
      dropped_in = dropped_ff;
      for (int r = 0; r < NUM_ROLES; r++) begin
         cnt_in[r]    = cnt_ff[r];
         rd_ptr_in[r] = rd_ptr_ff[r];
         wr_ptr_in[r] = wr_ptr_ff[r];
         wr_en[r]     = 1'b0;
      end
      if (exec) begin
         dropped_in = 1'b0;
         for (int r = 0; r < NUM_ROLES; r++) begin
            if (cmd.push && (cmd.role == 2'(r))) begin
               if (total == TW'(DEPTH)) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en[r]     = 1'b1;
                  wr_ptr_in[r] = next_ptr(wr_ptr_ff[r]);
                  cnt_in[r]    = cnt_ff[r] + 1'b1;
               end
            end
            if (have[r] && ((cmd.pop_role && (cmd.role == 2'(r))) ||
                            (cmd.take_group && (&have)))) begin
               rd_ptr_in[r] = next_ptr(rd_ptr_ff[r]);
               cnt_in[r]    = cnt_ff[r] - 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_EXEC:  if (cmd_valid) state_in = S_READ;
         S_READ:  state_in = S_DONE;
         S_DONE:  if (out_ready) state_in = S_EXEC;
         default: state_in = S_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_EXEC;
         for (int r = 0; r < NUM_ROLES; r++) begin
            cnt_ff[r]    <= '0;
            rd_ptr_ff[r] <= '0;
            wr_ptr_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         for (int r = 0; r < NUM_ROLES; r++) begin
            cnt_ff[r]    <= cnt_in[r];
            rd_ptr_ff[r] <= rd_ptr_in[r];
            wr_ptr_ff[r] <= wr_ptr_in[r];
         end
      end
      dropped_ff <= dropped_in;
   end

   for (genvar g = 0; g < NUM_ROLES; g++) begin : g_role
      logic [SW+ENTRY_ID_BITS-1:0] head_ext;
      rmgq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_ptr_ff[g]),
         .wr_data (cmd.id[SW-1:0]),
         .rd_en   (state_ff == S_READ),
         .rd_addr (rd_ptr_ff[g]),
         .rd_data (head[g])
      );
      assign head_ext   = {{ENTRY_ID_BITS{1'b0}}, head[g]};
      assign head_id[g] = have[g] ? head_ext[ENTRY_ID_BITS-1:0] : '0;
   end

   assign total_ext = {{(CW + FILL_BITS - TW){1'b0}}, total};
   assign out_valid = (state_ff == S_DONE);
   assign out_data  = {3'b000, dropped_ff,
                       head_id[2], have[2], head_id[1], have[1],
                       head_id[0], have[0], (&have), total_ext[FILL_BITS-1:0]};

endmodule

>>> hdl/role_matched_group_queue.sv
// Top level of the role matched group queue.
//
// Request beats enter on the req_ channel and each one yields exactly one
// response beat on the rsp_ channel, in order. A request either pushes an
// identifier with a role, pops the frontmost entry of one role, pops one
// entry of every role when all three are held, or only queries the state.
// The response reports the count, the frontmost identifier of each role with
// its valid flag, whether a full group is held, and whether a push was
// dropped because the queue held DEPTH entries.
// A front end decodes requests into a two-entry queue; a back end keeps one
// ring list per role in RAM. Each request passes the back-end states that
// update pointers and write, read the heads and present the result, in that
// order; the back end takes no new request until the receiver has taken the
// response to the last one.
// Reset empties the queue at once; no clearing pass is needed.
// When the receiver stalls, the response holds steady and the front queue
// takes up to two more requests before req_tready falls.
module role_matched_group_queue #(
   parameter int DEPTH   = rmgq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = rmgq_pkg::ID_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op [1:0], entry_id [17:2], zero fill above
   input  logic [23:0] req_tdata,
   // role [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fill_count, group_ready, defender_valid, defender_id, hunter_valid,
   // hunter_id, bard_valid, bard_id, push_dropped, zero fill above
   output logic [63:0] rsp_tdata
);
   import rmgq_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   rmgq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tdata[1:0]),
      .in_id     (req_tdata[17:2]),
      .in_role   (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   rmgq_back #(.DEPTH(DEPTH), .ID_BITS(ID_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

>>> sim/role_matched_group_queue_checker.sv
// Checker that predicts and compares the response beats of the role matched group queue.
`timescale 1ns / 1ps
module role_matched_group_queue_checker #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   import rmgq_pkg::*;

   typedef struct packed {
      logic                     push_dropped;
      logic [15:0]              bard_id;
      logic                     bard_valid;
      logic [15:0]              hunter_id;
      logic                     hunter_valid;
      logic [15:0]              defender_id;
      logic                     defender_valid;
      logic                     group_ready;
      logic [FILL_BITS-1:0]     fill_count;
   } status_type;

   logic [15:0] queue_ids[$];
   logic [1:0]  queue_roles[$];
   status_type  expected_status[$];

   function automatic int front_of(logic [1:0] which);
      for (int k = 0; k < queue_ids.size(); k++) begin
         if (queue_roles[k] == which) return k;
      end
      return -1;
   endfunction

   function automatic void remove_front(logic [1:0] which);
      int at;
      at = front_of(which);
      if (at >= 0) begin
         queue_ids.delete(at);
         queue_roles.delete(at);
      end
   endfunction

   function automatic status_type apply_request(op_type op, logic [15:0] id,
                                                logic [1:0] role);
      status_type s;
      int at;
      s = '0;
      case (op)
         OP_PUSH: begin
            if (role != ROLE_NONE) begin
               if (queue_ids.size() >= DEPTH) begin
                  s.push_dropped = 1'b1;
               end else begin
                  queue_ids.push_back(id);
                  queue_roles.push_back(role);
               end
            end
         end
         OP_POP: begin
            if (role != ROLE_NONE) remove_front(role);
         end
         OP_GROUP: begin
            if (front_of(2'd0) >= 0 && front_of(2'd1) >= 0 && front_of(2'd2) >= 0) begin
               remove_front(2'd0);
               remove_front(2'd1);
               remove_front(2'd2);
            end
         end
         default: ;
      endcase
      s.fill_count = FILL_BITS'(queue_ids.size());
      at = front_of(2'd0);
      if (at >= 0) begin s.defender_valid = 1'b1; s.defender_id = queue_ids[at]; end
      at = front_of(2'd1);
      if (at >= 0) begin s.hunter_valid = 1'b1; s.hunter_id = queue_ids[at]; end
      at = front_of(2'd2);
      if (at >= 0) begin s.bard_valid = 1'b1; s.bard_id = queue_ids[at]; end
      s.group_ready = s.defender_valid && s.hunter_valid && s.bard_valid;
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
   end

   assign pending_count = expected_status.size();

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(apply_request(op_type'(req_tdata[1:0]),
                                                    req_tdata[17:2], req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(status_type)-1:0];
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = expected_status.pop_front();
               if (got.fill_count != want.fill_count)
                  report_mismatch("fill_count", got.fill_count, want.fill_count);
               if (got.group_ready != want.group_ready)
                  report_mismatch("group_ready", got.group_ready, want.group_ready);
               if (got.defender_valid != want.defender_valid)
                  report_mismatch("defender_valid", got.defender_valid, want.defender_valid);
               if (got.defender_id != want.defender_id)
                  report_mismatch("defender_id", got.defender_id, want.defender_id);
               if (got.hunter_valid != want.hunter_valid)
                  report_mismatch("hunter_valid", got.hunter_valid, want.hunter_valid);
               if (got.hunter_id != want.hunter_id)
                  report_mismatch("hunter_id", got.hunter_id, want.hunter_id);
               if (got.bard_valid != want.bard_valid)
                  report_mismatch("bard_valid", got.bard_valid, want.bard_valid);
               if (got.bard_id != want.bard_id)
                  report_mismatch("bard_id", got.bard_id, want.bard_id);
               if (got.push_dropped != want.push_dropped)
                  report_mismatch("push_dropped", got.push_dropped, want.push_dropped);
               if (rsp_tdata[63:$bits(status_type)] != '0)
                  report_mismatch("fill bits", 1, 0);
            end
         end
      end
   end

endmodule

>>> sim/tb_role_matched_group_queue.sv
// Testbench top that drives requests and back pressure into the role matched group queue.
`timescale 1ns / 1ps
module tb_role_matched_group_queue;
   import rmgq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   int          rsp_idle_left;
   bit          quiet_phase;
   bit          long_hold;

   role_matched_group_queue DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   role_matched_group_queue_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      quiet_phase  = 1'b0;
      long_hold    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= reset ? 0 : cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offers one request beat and holds it until accepted, outside the quiet phase sometimes after a random gap.
   task automatic send_request(op_type op, logic [15:0] id, logic [1:0] role);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, id, op};
      req_tuser  <= role;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(int push_weight);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < push_weight)
         send_request(OP_PUSH, 16'($urandom), 2'($urandom_range(0, 2)));
      else if (pick < push_weight + 25)
         send_request(OP_POP, 16'($urandom), 2'($urandom_range(0, 2)));
      else if (pick < push_weight + 40)
         send_request(OP_GROUP, 16'($urandom), 2'($urandom));
      else if (pick < push_weight + 45)
         send_request(OP_POP, 16'($urandom), ROLE_NONE);
      else
         send_request(op_type'($urandom_range(0, 3)), 16'($urandom), 2'($urandom));
   endtask

   always @(posedge clock) begin
      if (reset || long_hold) begin
         rsp_tready    <= 1'b0;
         rsp_idle_left <= 0;
      end else if (quiet_phase) begin
         rsp_tready <= 1'b1;
      end else if (rsp_idle_left != 0) begin
         rsp_tready    <= 1'b0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready    <= 1'b0;
         rsp_idle_left <= $urandom_range(0, 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Long receiver hold-off so the request side fills and stalls.
   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      long_hold <= 1'b1;
      repeat (200) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      int wait_cycles;
      @(negedge reset);
      @(posedge clock);
      send_request(OP_QUERY, 16'hFFFF, 2'd3);
      send_request(OP_POP, 16'h0000, 2'd0);
      send_request(OP_GROUP, 16'h0000, 2'd0);
      send_request(OP_PUSH, 16'h0000, 2'd0);
      send_request(OP_PUSH, 16'hFFFF, 2'd1);
      send_request(OP_PUSH, 16'hAAAA, ROLE_NONE);
      send_request(OP_GROUP, 16'h5555, 2'd0);
      send_request(OP_PUSH, 16'h5555, 2'd2);
      send_request(OP_PUSH, 16'h1234, 2'd1);
      send_request(OP_PUSH, 16'h8001, 2'd0);
      send_request(OP_POP, 16'h0000, ROLE_NONE);
      send_request(OP_POP, 16'h0000, 2'd1);
      send_request(OP_GROUP, 16'h0000, 2'd3);
      send_request(OP_POP, 16'h0000, 2'd2);
      send_request(OP_QUERY, 16'h0000, 2'd0);
      for (int k = 0; k < 132; k++)
         send_request(OP_PUSH, 16'($urandom), 2'(k % 3));
      for (int k = 0; k < 45; k++)
         send_request(OP_GROUP, 16'($urandom), 2'($urandom));
      for (int k = 0; k < 430; k++)
         send_random(k < 215 ? 50 : 30);
      quiet_phase = 1'b1;
      for (int k = 0; k < 80; k++)
         send_random(40);
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_count == 0 && fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
